>>> rtl/pdcb_pkg.sv
// Package with shared types, constants and helpers for the press duration classifier.
`timescale 1ns / 1ps
`default_nettype none

package pdcb_pkg;

   localparam int COUNT_BITS = 8;
   localparam int CMP_BITS   = (COUNT_BITS > 8) ? COUNT_BITS : 8;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] HOLD_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      CLS_RELEASED = 2'd0,
      CLS_PRESSED  = 2'd1,
      CLS_MIDDLE   = 2'd2,
      CLS_LONG     = 2'd3
   } class_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_SLOW = 2'd1,
      MODE_FAST = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_SAMPLE_PERIOD = 3'd0,
      REG_MIDDLE_THRESH = 3'd1,
      REG_LONG_THRESH   = 3'd2,
      REG_SLOW_PERIOD   = 3'd3,
      REG_FAST_PERIOD   = 3'd4
   } reg_index_type;

   localparam logic [7:0] RST_SAMPLE_PERIOD = 8'd50;
   localparam logic [7:0] RST_MIDDLE_THRESH = 8'd40;
   localparam logic [7:0] RST_LONG_THRESH   = 8'd100;
   localparam logic [7:0] RST_SLOW_PERIOD   = 8'd250;
   localparam logic [7:0] RST_FAST_PERIOD   = 8'd100;

   typedef struct packed {
      logic [7:0] sample_period;
      logic [7:0] middle_threshold;
      logic [7:0] long_threshold;
      logic [7:0] slow_blink_period;
      logic [7:0] fast_blink_period;
   } cfg_type;

   typedef struct packed {
      logic      led_level;
      class_type press_class;
      mode_type  blink_mode;
   } result_type;

   function automatic logic [7:0] blink_reload(mode_type mode, cfg_type cfg);
      logic [7:0] value;
      value = 8'd0;
      unique case (mode)
         MODE_SLOW: value = cfg.slow_blink_period;
         MODE_FAST: value = cfg.fast_blink_period;
         default:   value = 8'd0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

>>> rtl/press_duration_classifier_blinker.sv
// The result register loads at the edge that accepts the tick transaction.
// One tick per cycle unless stalled; the update is a single pass of counter compares.
// A full result register with the result side stalled holds off the request side.
// Synchronous active-high reset restores the default configuration, clears the
// classifier state, loads the sample countdown with its default and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module press_duration_classifier_blinker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_button_level,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic                           rsp_led_level,
   output      logic [1:0]                     rsp_press_class,
   output      logic [1:0]                     rsp_blink_mode,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [pdcb_pkg::ADDR_BITS-1:0] csr_paddr,
   input  wire logic [pdcb_pkg::DATA_BITS-1:0] csr_pwdata,
   output      logic [pdcb_pkg::DATA_BITS-1:0] csr_prdata,
   output      logic                           csr_pready
);

   pdcb_pkg::cfg_type     cfg_ff, cfg_in;
   pdcb_pkg::result_type  core_result;
   pdcb_pkg::result_type  rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  csr_write;
   pdcb_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = pdcb_pkg::reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            pdcb_pkg::REG_SAMPLE_PERIOD: cfg_in.sample_period     = csr_pwdata[7:0];
            pdcb_pkg::REG_MIDDLE_THRESH: cfg_in.middle_threshold  = csr_pwdata[7:0];
            pdcb_pkg::REG_LONG_THRESH:   cfg_in.long_threshold    = csr_pwdata[7:0];
            pdcb_pkg::REG_SLOW_PERIOD:   cfg_in.slow_blink_period = csr_pwdata[7:0];
            pdcb_pkg::REG_FAST_PERIOD:   cfg_in.fast_blink_period = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         pdcb_pkg::REG_SAMPLE_PERIOD: csr_prdata[7:0] = cfg_ff.sample_period;
         pdcb_pkg::REG_MIDDLE_THRESH: csr_prdata[7:0] = cfg_ff.middle_threshold;
         pdcb_pkg::REG_LONG_THRESH:   csr_prdata[7:0] = cfg_ff.long_threshold;
         pdcb_pkg::REG_SLOW_PERIOD:   csr_prdata[7:0] = cfg_ff.slow_blink_period;
         pdcb_pkg::REG_FAST_PERIOD:   csr_prdata[7:0] = cfg_ff.fast_blink_period;
         default:                     csr_prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period     <= pdcb_pkg::RST_SAMPLE_PERIOD;
         cfg_ff.middle_threshold  <= pdcb_pkg::RST_MIDDLE_THRESH;
         cfg_ff.long_threshold    <= pdcb_pkg::RST_LONG_THRESH;
         cfg_ff.slow_blink_period <= pdcb_pkg::RST_SLOW_PERIOD;
         cfg_ff.fast_blink_period <= pdcb_pkg::RST_FAST_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A new transaction is taken whenever the result register is empty or drains now.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   pdcb_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .button_level (req_button_level),
      .cfg          (cfg_ff),
      .result       (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_level   = rsp_ff.led_level;
   assign rsp_press_class = rsp_ff.press_class;
   assign rsp_blink_mode  = rsp_ff.blink_mode;

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("Request side stalled with an empty result register.");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("Accepted transaction produced no result.");

   a_released_no_blink: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_press_class == pdcb_pkg::CLS_RELEASED) |->
         (rsp_blink_mode == pdcb_pkg::MODE_NONE))
      else $error("Blinking while the button is classified as released.");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result register not empty after reset.");

endmodule

`default_nettype wire

>>> rtl/pdcb_core.sv
// Classifier state registers and the per-tick update logic.
`timescale 1ns / 1ps
`default_nettype none

module pdcb_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic                 button_level,
   input  wire pdcb_pkg::cfg_type    cfg,
   output pdcb_pkg::result_type      result
);

   logic [7:0]                      sample_countdown_ff, sample_countdown_in;
   logic                            was_pressed_ff, was_pressed_in;
   logic [pdcb_pkg::COUNT_BITS-1:0] hold_samples_ff, hold_samples_in;
   pdcb_pkg::class_type             class_ff, class_in;
   pdcb_pkg::mode_type              mode_ff, mode_in;
   logic [7:0]                      blink_countdown_ff, blink_countdown_in;
   logic                            led_ff, led_in;

   always_comb begin
      logic                            pressed_now;
      logic [7:0]                      sample_dec;
      logic [7:0]                      blink_dec;
      logic [pdcb_pkg::CMP_BITS-1:0]   hold_wide;
      logic [pdcb_pkg::CMP_BITS-1:0]   middle_wide;
      logic [pdcb_pkg::CMP_BITS-1:0]   long_wide;
      pressed_now = ~button_level;
      sample_dec  = sample_countdown_ff - 8'd1;

      sample_countdown_in = sample_dec;
      was_pressed_in      = was_pressed_ff;
      hold_samples_in     = hold_samples_ff;
      class_in            = class_ff;
      mode_in             = mode_ff;
      blink_countdown_in  = blink_countdown_ff;
      led_in              = led_ff;

      middle_wide = pdcb_pkg::CMP_BITS'(cfg.middle_threshold);
      long_wide   = pdcb_pkg::CMP_BITS'(cfg.long_threshold);

      if (sample_dec == 8'd0) begin
         sample_countdown_in = cfg.sample_period;
         if (!was_pressed_ff && pressed_now) begin
            class_in        = pdcb_pkg::CLS_PRESSED;
            hold_samples_in = '0;
         end
         if (was_pressed_ff && !pressed_now) begin
            class_in = pdcb_pkg::CLS_RELEASED;
         end
         was_pressed_in = pressed_now;

         hold_wide = pdcb_pkg::CMP_BITS'(hold_samples_in);
         if (class_in != pdcb_pkg::CLS_RELEASED && hold_wide <= long_wide &&
             hold_samples_in != pdcb_pkg::HOLD_MAX) begin
            hold_samples_in = hold_samples_in + 1'b1;
            hold_wide       = pdcb_pkg::CMP_BITS'(hold_samples_in);
            if (hold_wide >= middle_wide) begin
               class_in = pdcb_pkg::CLS_MIDDLE;
            end
            if (hold_wide >= long_wide) begin
               class_in = pdcb_pkg::CLS_LONG;
            end
         end

         if (class_in != class_ff) begin
            unique case (class_in)
               pdcb_pkg::CLS_RELEASED: mode_in = pdcb_pkg::MODE_NONE;
               pdcb_pkg::CLS_PRESSED:  led_in  = ~led_ff;
               pdcb_pkg::CLS_MIDDLE:   mode_in = pdcb_pkg::MODE_SLOW;
               pdcb_pkg::CLS_LONG:     mode_in = pdcb_pkg::MODE_FAST;
            endcase
            if (mode_in != mode_ff) begin
               blink_countdown_in = pdcb_pkg::blink_reload(mode_in, cfg);
            end
         end
      end else begin
         hold_wide = '0;
      end

      // The blinker runs after sampling, on the mode that sampling left.
      blink_dec = blink_countdown_in - 8'd1;
      if (mode_in != pdcb_pkg::MODE_NONE) begin
         if (blink_dec == 8'd0) begin
            led_in             = ~led_in;
            blink_countdown_in = pdcb_pkg::blink_reload(mode_in, cfg);
         end else begin
            blink_countdown_in = blink_dec;
         end
      end

      result.led_level   = led_in;
      result.press_class = class_in;
      result.blink_mode  = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_countdown_ff <= pdcb_pkg::RST_SAMPLE_PERIOD;
         was_pressed_ff      <= 1'b0;
         hold_samples_ff     <= '0;
         class_ff            <= pdcb_pkg::CLS_RELEASED;
         mode_ff             <= pdcb_pkg::MODE_NONE;
         blink_countdown_ff  <= 8'd0;
         led_ff              <= 1'b0;
      end else if (step) begin
         sample_countdown_ff <= sample_countdown_in;
         was_pressed_ff      <= was_pressed_in;
         hold_samples_ff     <= hold_samples_in;
         class_ff            <= class_in;
         mode_ff             <= mode_in;
         blink_countdown_ff  <= blink_countdown_in;
         led_ff              <= led_in;
      end
   end

endmodule

`default_nettype wire
